### design/cpu_clock_divider_governor_defines.svh
// ----------------------------------------------------------------------------
// Clock divider governor assertion macros
// Shared property wrappers for the checker of the governor.
// ----------------------------------------------------------------------------
`ifndef CPU_CLOCK_DIVIDER_GOVERNOR_DEFINES_SVH
`define CPU_CLOCK_DIVIDER_GOVERNOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCDG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccdg checker: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define CCDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccdg checker: next-cycle property violated");

`endif

### design/ccdg_pkg.sv
// ----------------------------------------------------------------------------
// Clock divider governor package
// Widths, codes, constants and the command struct shared by the governor.
// ----------------------------------------------------------------------------
`default_nettype none

package ccdg_pkg;

    // Field and datapath widths.
    localparam int DIV_W      = 9;
    localparam int TGT_W      = 10;
    localparam int IRQ_W      = 16;
    localparam int LOOP_W     = 24;
    localparam int CNT_W      = 8;
    localparam int MARGIN_W   = 5;
    localparam int ROOM_W     = 14;
    localparam int SROOM_W    = ROOM_W + 1;
    localparam int K_W        = 10;
    localparam int PROD_W     = K_W + DIV_W;
    localparam int ACTION_W   = 2;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default divider limits.
    localparam int DEF_MAX_LINEAR_DIVIDER = 256;
    localparam int DEF_MAX_POW2_DIVIDER   = 4;

    // Decision thresholds.
    localparam logic [LOOP_W-1:0]   LOOP_LIMIT_US   = 24'd2000;
    localparam logic [IRQ_W-1:0]    FAST_LOAD_LIMIT = 16'd900;
    localparam logic [SROOM_W-1:0]  SLOW_LOAD_LIMIT = 15'd850;
    localparam logic [MARGIN_W-1:0] MARGIN_POW2     = 5'd25;
    localparam logic [MARGIN_W-1:0] MARGIN_LINEAR   = 5'd7;
    localparam logic [CNT_W-1:0]    POINTS_RESET    = 8'd100;
    localparam logic [CNT_W-1:0]    COUNT_MAX       = 8'hFF;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_SAMPLE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MAX_SPEED  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MANUAL_SET = 2'd2;

    // Reported directions.
    localparam logic [DIR_W-1:0] DIR_NONE   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FASTER = 2'd1;
    localparam logic [DIR_W-1:0] DIR_SLOWER = 2'd2;
    localparam logic [DIR_W-1:0] DIR_SET    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS_TARGET = 2'd2;

    // Step commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;
        logic room;
        logic scale;
        logic prod;
        logic apply;
    } t_cmd;

endpackage

`default_nettype wire

### design/ccdg_ctrl.sv
// ----------------------------------------------------------------------------
// Clock divider governor sequencer
// Steps one request through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ccdg_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOM,
        S_SCALE,
        S_PROD,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   out_free;

    // The result register may be loaded when it is empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Step decode.
    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid && r_in_ready;
        o_cmd.room    = (r_state == S_ROOM);
        o_cmd.scale   = (r_state == S_SCALE);
        o_cmd.prod    = (r_state == S_PROD);
        o_cmd.apply   = (r_state == S_APPLY) && out_free;
    end

    // State and handshake registers.
    // The input side stays closed during reset and opens in the cycle after its release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.apply) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_ROOM;
                        r_in_ready <= 1'b0;
                    end else begin
                        r_in_ready <= 1'b1;
                    end
                end
                S_ROOM: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### design/ccdg_datapath.sv
// ----------------------------------------------------------------------------
// Clock divider governor datapath
// Holds configuration and governor state and evaluates one request in steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdg_datapath #(
    parameter int MAX_LINEAR_DIVIDER = ccdg_pkg::DEF_MAX_LINEAR_DIVIDER,
    parameter int MAX_POW2_DIVIDER   = ccdg_pkg::DEF_MAX_POW2_DIVIDER
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ccdg_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_cfg_we,
    input  wire logic [ccdg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ccdg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ccdg_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [ccdg_pkg::IRQ_W-1:0]      i_irq_time_us,
    input  wire logic [ccdg_pkg::LOOP_W-1:0]     i_main_loop_us,
    input  wire logic [ccdg_pkg::DIV_W-1:0]      i_requested_divider,
    output logic [ccdg_pkg::DIV_W-1:0]           o_divider,
    output logic                                 o_changed,
    output logic [ccdg_pkg::DIR_W-1:0]           o_direction
);

    localparam int DIV_W   = ccdg_pkg::DIV_W;
    localparam int TGT_W   = ccdg_pkg::TGT_W;
    localparam int IRQ_W   = ccdg_pkg::IRQ_W;
    localparam int CNT_W   = ccdg_pkg::CNT_W;
    localparam int ROOM_W  = ccdg_pkg::ROOM_W;
    localparam int SROOM_W = ccdg_pkg::SROOM_W;
    localparam int K_W     = ccdg_pkg::K_W;
    localparam int PROD_W  = ccdg_pkg::PROD_W;
    localparam int PK2_W   = IRQ_W + 1;

    localparam logic [TGT_W-1:0] MAX_LIN_T  = TGT_W'(MAX_LINEAR_DIVIDER);
    localparam logic [TGT_W-1:0] MAX_POW2_T = TGT_W'(MAX_POW2_DIVIDER);
    localparam logic [TGT_W-1:0] ONE_T      = TGT_W'(1);

    // Largest power of two not above the value.
    function automatic logic [TGT_W-1:0] pow2_floor(input logic [TGT_W-1:0] v);
        logic [TGT_W-1:0] p;
        p = '0;
        for (int i = 0; i < TGT_W; i++) begin
            if (v[i]) begin
                p = ONE_T << i;
            end
        end
        return p;
    endfunction

    // Configuration and governor state.
    logic                r_mode;
    logic                r_manual;
    logic [CNT_W-1:0]    r_target;
    logic [DIV_W-1:0]    r_div;
    logic [IRQ_W-1:0]    r_peak;
    logic [CNT_W-1:0]    r_count;
    logic                r_skip;

    // Captured request.
    logic [ccdg_pkg::ACTION_W-1:0] r_action;
    logic [IRQ_W-1:0]              r_irq;
    logic [ccdg_pkg::LOOP_W-1:0]   r_loop;
    logic [DIV_W-1:0]              r_req;

    // Working registers of the evaluation steps.
    logic [IRQ_W-1:0]  r_peak1;
    logic [CNT_W-1:0]  r_cnt1;
    logic [ROOM_W-1:0] r_room;
    logic              r_fast_loop;
    logic              r_fast_peak;
    logic              r_sroom_ok;
    logic [K_W-1:0]    r_k;
    logic              r_p_lt_k;
    logic              r_p2_lt_k;
    logic [PROD_W-1:0] r_prod;

    // Result registers.
    logic [DIV_W-1:0]           r_out_div;
    logic                       r_out_changed;
    logic [ccdg_pkg::DIR_W-1:0] r_out_dir;

    // Step one: sample statistics and the safety room.
    logic [ccdg_pkg::MARGIN_W-1:0] margin;
    logic [ROOM_W-1:0]             n_room;
    logic [IRQ_W-1:0]              n_peak1;
    logic [CNT_W-1:0]              n_cnt1;

    always_comb begin
        margin  = r_mode ? ccdg_pkg::MARGIN_LINEAR : ccdg_pkg::MARGIN_POW2;
        n_room  = ROOM_W'(margin) * ROOM_W'(r_div);
        n_cnt1  = (r_count != ccdg_pkg::COUNT_MAX) ? r_count + CNT_W'(1) : r_count;
        n_peak1 = r_peak;
        if (r_irq > r_peak) begin
            n_peak1 = r_irq;
            n_cnt1  = '0;
        end
    end

    // Step two: speed-up tests and the room scaled to the slower clock.
    // In linear mode the room is margin times divider, so its scaled value
    // is exactly the room plus the margin.
    logic [SROOM_W-1:0] sroom;
    logic               n_fast_peak;

    always_comb begin
        n_fast_peak = (r_room <= ROOM_W'(ccdg_pkg::FAST_LOAD_LIMIT)) &&
                      (r_peak1 > (ccdg_pkg::FAST_LOAD_LIMIT - IRQ_W'(r_room)));
        if (r_mode) begin
            sroom = SROOM_W'(r_room) + SROOM_W'(ccdg_pkg::MARGIN_LINEAR);
        end else begin
            sroom = {r_room, 1'b0};
        end
    end

    // Step three: scaled peak tests. For the linear mode,
    // peak + peak / d < k holds when peak < k and peak < (k - peak) * d.
    logic [K_W-1:0]    k_diff;
    logic [PROD_W-1:0] n_prod;

    always_comb begin
        k_diff = r_k - r_peak1[K_W-1:0];
        n_prod = PROD_W'(k_diff) * PROD_W'(r_div);
    end

    // Step four: decision.
    logic                       slow_ok;
    logic [TGT_W-1:0]           fast_tgt;
    logic [TGT_W-1:0]           slow_tgt;
    logic [ccdg_pkg::DIR_W-1:0] d_dir;
    logic                       d_apply;
    logic [TGT_W-1:0]           d_tgt;
    logic                       d_sample;
    logic                       d_skip_clr;
    logic                       d_max;

    always_comb begin
        if (r_mode) begin
            slow_ok  = r_sroom_ok && r_p_lt_k && (PROD_W'(r_peak1) < r_prod);
            fast_tgt = (r_div > DIV_W'(1)) ? TGT_W'(r_div) - ONE_T : TGT_W'(r_div);
            slow_tgt = (TGT_W'(r_div) < MAX_LIN_T) ? TGT_W'(r_div) + ONE_T : TGT_W'(r_div);
        end else begin
            slow_ok  = r_sroom_ok && r_p2_lt_k;
            fast_tgt = TGT_W'(r_div >> 1);
            slow_tgt = {r_div, 1'b0};
        end

        d_dir      = ccdg_pkg::DIR_NONE;
        d_apply    = 1'b0;
        d_tgt      = TGT_W'(r_div);
        d_sample   = 1'b0;
        d_skip_clr = 1'b0;
        d_max      = 1'b0;
        case (r_action)
            ccdg_pkg::ACT_SAMPLE: begin
                if (!r_manual) begin
                    if (r_skip) begin
                        d_skip_clr = 1'b1;
                    end else begin
                        d_sample = 1'b1;
                        if (r_fast_loop || r_fast_peak) begin
                            d_dir   = ccdg_pkg::DIR_FASTER;
                            d_apply = 1'b1;
                            d_tgt   = fast_tgt;
                        end else if ((r_cnt1 >= r_target) && slow_ok) begin
                            d_dir   = ccdg_pkg::DIR_SLOWER;
                            d_apply = 1'b1;
                            d_tgt   = slow_tgt;
                        end
                    end
                end
            end
            ccdg_pkg::ACT_MAX_SPEED: begin
                if (!r_manual) begin
                    d_max   = 1'b1;
                    d_dir   = ccdg_pkg::DIR_SET;
                    d_apply = 1'b1;
                    d_tgt   = ONE_T;
                end
            end
            ccdg_pkg::ACT_MANUAL_SET: begin
                if (r_manual) begin
                    d_dir   = ccdg_pkg::DIR_SET;
                    d_apply = 1'b1;
                    d_tgt   = TGT_W'(r_req);
                end
            end
            default: begin
                d_dir = ccdg_pkg::DIR_NONE;
            end
        endcase
    end

    // Clamp the target to the range of the mode and round in power-of-two mode.
    logic [TGT_W-1:0] tgt_c;
    logic [DIV_W-1:0] new_div;
    logic             div_chg;

    always_comb begin
        tgt_c = d_tgt;
        if (r_mode) begin
            if (tgt_c > MAX_LIN_T) begin
                tgt_c = MAX_LIN_T;
            end
        end else begin
            if (tgt_c > MAX_POW2_T) begin
                tgt_c = MAX_POW2_T;
            end
        end
        if (tgt_c == '0) begin
            tgt_c = ONE_T;
        end
        if (r_mode) begin
            new_div = tgt_c[DIV_W-1:0];
        end else begin
            new_div = DIV_W'(pow2_floor(tgt_c));
        end
        div_chg = d_apply && (new_div != r_div);
    end

    // Next governor state.
    logic [DIV_W-1:0] n_div;
    logic [IRQ_W-1:0] n_peak;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] n_target;
    logic             n_skip;

    always_comb begin
        n_div    = div_chg ? new_div : r_div;
        n_skip   = div_chg ? 1'b1 : (d_skip_clr ? 1'b0 : r_skip);
        n_peak   = r_peak;
        n_count  = r_count;
        n_target = r_target;
        if (d_sample) begin
            n_peak  = r_peak1;
            n_count = r_fast_loop ? '0 : r_cnt1;
        end
        if (d_max) begin
            n_peak   = '0;
            n_count  = '0;
            n_target = ccdg_pkg::POINTS_RESET;
        end
        if (div_chg && !r_mode) begin
            n_peak  = '0;
            n_count = '0;
        end
        if (d_sample && (n_count >= r_target)) begin
            n_peak  = '0;
            n_count = '0;
        end
    end

    // Configuration and governor state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_manual <= 1'b0;
            r_target <= ccdg_pkg::POINTS_RESET;
            r_div    <= DIV_W'(1);
            r_peak   <= '0;
            r_count  <= '0;
            r_skip   <= 1'b0;
        end else if (i_cmd.apply) begin
            r_target <= n_target;
            r_div    <= n_div;
            r_peak   <= n_peak;
            r_count  <= n_count;
            r_skip   <= n_skip;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ccdg_pkg::CFG_DIVIDER_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                ccdg_pkg::CFG_MANUAL_MODE: begin
                    r_manual <= i_cfg_data[0];
                end
                ccdg_pkg::CFG_POINTS_TARGET: begin
                    r_target <= i_cfg_data;
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Request capture and step registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_irq    <= i_irq_time_us;
            r_loop   <= i_main_loop_us;
            r_req    <= i_requested_divider;
        end
        if (i_cmd.room) begin
            r_peak1 <= n_peak1;
            r_cnt1  <= n_cnt1;
            r_room  <= n_room;
        end
        if (i_cmd.scale) begin
            r_fast_loop <= (r_loop > ccdg_pkg::LOOP_LIMIT_US);
            r_fast_peak <= n_fast_peak;
            r_sroom_ok  <= (sroom <= ccdg_pkg::SLOW_LOAD_LIMIT);
            r_k         <= K_W'(ccdg_pkg::SLOW_LOAD_LIMIT - sroom);
        end
        if (i_cmd.prod) begin
            r_p_lt_k  <= (r_peak1 < IRQ_W'(r_k));
            r_p2_lt_k <= ({r_peak1, 1'b0} < PK2_W'(r_k));
            r_prod    <= n_prod;
        end
        if (i_cmd.apply) begin
            r_out_div     <= n_div;
            r_out_changed <= div_chg;
            r_out_dir     <= d_dir;
        end
    end

    assign o_divider   = r_out_div;
    assign o_changed   = r_out_changed;
    assign o_direction = r_out_dir;

endmodule

`default_nettype wire

### design/cpu_clock_divider_governor.sv
// An accepted request passes through the room, scale, product and apply steps in turn;
// its result is registered when the result register is free, and a stalled result holds
// the request in the apply step. No new request is taken until all four steps are done.
// Reset: synchronous, active low; divider 1, statistics cleared, points target 100.
// The input ready output stays low during reset and rises in the cycle after release.
// ----------------------------------------------------------------------------
// Clock divider governor
// Load-driven divider selection with power-of-two and linear modes, plus manual setting.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_clock_divider_governor #(
    parameter int MAX_LINEAR_DIVIDER = ccdg_pkg::DEF_MAX_LINEAR_DIVIDER,
    parameter int MAX_POW2_DIVIDER   = ccdg_pkg::DEF_MAX_POW2_DIVIDER
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ccdg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ccdg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [ccdg_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [ccdg_pkg::IRQ_W-1:0]      i_irq_time_us,
    input  wire logic [ccdg_pkg::LOOP_W-1:0]     i_main_loop_us,
    input  wire logic [ccdg_pkg::DIV_W-1:0]      i_requested_divider,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ccdg_pkg::DIV_W-1:0]           o_divider,
    output logic                                 o_changed,
    output logic [ccdg_pkg::DIR_W-1:0]           o_direction
);

    ccdg_pkg::t_cmd cmd;

    // Request sequencer and handshakes.
    ccdg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // Governor state and evaluation.
    ccdg_datapath #(
        .MAX_LINEAR_DIVIDER (MAX_LINEAR_DIVIDER),
        .MAX_POW2_DIVIDER   (MAX_POW2_DIVIDER)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_action            (i_action),
        .i_irq_time_us       (i_irq_time_us),
        .i_main_loop_us      (i_main_loop_us),
        .i_requested_divider (i_requested_divider),
        .o_divider           (o_divider),
        .o_changed           (o_changed),
        .o_direction         (o_direction)
    );

endmodule

`default_nettype wire

### design/ccdg_checker.sv
// ----------------------------------------------------------------------------
// Clock divider governor checker
// Port-level properties of the governor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cpu_clock_divider_governor_defines.svh"

module ccdg_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [ccdg_pkg::DIV_W-1:0]      o_divider,
    input wire logic                            o_changed,
    input wire logic [ccdg_pkg::DIR_W-1:0]      o_direction
);

    // A stalled result keeps its fields.
    `CCDG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_divider) && $stable(o_changed) && $stable(o_direction))

    // A changed divider always comes with a decision.
    `CCDG_ASSERT_NOW(a_changed_dir, i_clk, i_rst_n, o_out_valid && o_changed, o_direction != ccdg_pkg::DIR_NONE)

    // A valid result never carries a zero divider.
    `CCDG_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, o_out_valid, o_divider != '0)

    // Only one request is evaluated at a time.
    `CCDG_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // An accepted request does not show its result in the cycle after it is taken.
    `CCDG_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid, !o_out_valid)

endmodule

bind cpu_clock_divider_governor ccdg_checker u_checker (.*);

`default_nettype wire
